### hw/rtl/ibbt_pkg.sv
// Shared constants, codes and types of the iterated box blur with tint.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none
package ibbt_pkg;

  localparam int RADIUS_DEF    = 5;
  localparam int PASSES_DEF    = 3;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W      = 24;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int TINT_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CNT_W      = 25;
  localparam int TC_W       = 14;
  localparam int FIFO_DEPTH = 4;

  localparam int TINT_FULL    = 100;
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_TINT_PERCENT = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_STAGE,
    BK_TAP,
    BK_ACC,
    BK_DIV,
    BK_WRITE,
    BK_TINT,
    BK_EMIT,
    BK_FINISH
  } bk_state_e;

  // One queued item: the pixel, whether it opens a frame, and that frame's size.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             first;
    logic [FW_W-1:0]  w;
    logic [FH_W-1:0]  h;
  } fifo_entry_t;

endpackage
`default_nettype wire

### hw/rtl/ibbt_if.sv
// Channel interfaces: pixel input, result output and configuration write.
// Depends on ibbt_pkg for field widths.
`default_nettype none
interface ibbt_in_if;
  logic                        valid;
  logic                        ready;
  logic [ibbt_pkg::PIX_W-1:0]  pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ibbt_out_if;
  logic                        valid;
  logic                        ready;
  logic [ibbt_pkg::PIX_W-1:0]  pixel_out;
  logic                        frame_done;
  modport source (output valid, output pixel_out, output frame_done, input ready);
  modport sink   (input valid, input pixel_out, input frame_done, output ready);
endinterface

interface ibbt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ibbt_pkg::CFG_IDX_W-1:0]   index;
  logic [ibbt_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/ibbt_front.sv
// Front end: accepts input beats, counts them per frame, latches frame size.
// Depends on ibbt_pkg; feeds ibbt_fifo.
`default_nettype none
module ibbt_front #(
  parameter int RADIUS    = ibbt_pkg::RADIUS_DEF,
  parameter int PASSES    = ibbt_pkg::PASSES_DEF,
  parameter int MAX_WIDTH = ibbt_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ibbt_pkg::PIX_W-1:0]    pixel_i,
  input  logic [ibbt_pkg::FW_W-1:0]     frame_width_i,
  input  logic [ibbt_pkg::FH_W-1:0]     frame_height_i,
  input  logic                          fifo_full_i,
  output logic                          push_o,
  output ibbt_pkg::fifo_entry_t         entry_o
);

  logic [ibbt_pkg::CNT_W-1:0] cnt_q, cnt_d, total_q, total_d;
  logic [ibbt_pkg::FW_W-1:0]  wl_q, wl_d, cw;
  logic [ibbt_pkg::FH_W-1:0]  hl_q, hl_d, ch;
  logic                       first, acc;

  always_comb begin
    if (frame_width_i == '0) begin
      cw = ibbt_pkg::FW_W'(1);
    end else if (32'(frame_width_i) > MAX_WIDTH) begin
      cw = ibbt_pkg::FW_W'(MAX_WIDTH);
    end else begin
      cw = frame_width_i;
    end
    if (frame_height_i == '0) begin
      ch = ibbt_pkg::FH_W'(1);
    end else if (32'(frame_height_i) > ibbt_pkg::MAX_HEIGHT) begin
      ch = ibbt_pkg::FH_W'(ibbt_pkg::MAX_HEIGHT);
    end else begin
      ch = frame_height_i;
    end
  end

  assign first      = (cnt_q == '0);
  assign in_ready_o = !fifo_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc;

  always_comb begin
    entry_o.pixel = pixel_i;
    entry_o.first = first;
    entry_o.w     = first ? cw : wl_q;
    entry_o.h     = first ? ch : hl_q;
  end

  // A frame lasts its pixels plus the pipeline latency in beats.
  always_comb begin
    cnt_d   = cnt_q;
    total_d = total_q;
    wl_d    = wl_q;
    hl_d    = hl_q;
    if (acc) begin
      if (first) begin
        wl_d    = cw;
        hl_d    = ch;
        total_d = ibbt_pkg::CNT_W'(32'(cw) * 32'(ch) + PASSES * RADIUS * (32'(cw) + 1));
        cnt_d   = ibbt_pkg::CNT_W'(1);
      end else if (cnt_q == total_q - ibbt_pkg::CNT_W'(1)) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + ibbt_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    wl_q    <= wl_d;
    hl_q    <= hl_d;
  end

endmodule
`default_nettype wire

### hw/rtl/ibbt_fifo.sv
// Short queue between front and back end.
// Depends on ibbt_pkg for the entry type and depth.
`default_nettype none
module ibbt_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ibbt_pkg::fifo_entry_t  entry_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output ibbt_pkg::fifo_entry_t  entry_o
);

  localparam int PW = $clog2(ibbt_pkg::FIFO_DEPTH);

  ibbt_pkg::fifo_entry_t store_q [ibbt_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(ibbt_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = store_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(ibbt_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == PW'(ibbt_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_q] <= entry_i;
  end

endmodule
`default_nettype wire

### hw/rtl/ibbt_back.sv
// Back end: runs each item through the blur stages one tap at a time, then tints.
// Depends on ibbt_pkg; holds the row-window and line-store memories.
`default_nettype none
module ibbt_back #(
  parameter int RADIUS    = ibbt_pkg::RADIUS_DEF,
  parameter int PASSES    = ibbt_pkg::PASSES_DEF,
  parameter int MAX_WIDTH = ibbt_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ent_valid_i,
  input  ibbt_pkg::fifo_entry_t         ent_i,
  output logic                          ent_pop_o,
  input  logic [ibbt_pkg::TINT_W-1:0]   tint_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ibbt_pkg::PIX_W-1:0]    pixel_out_o,
  output logic                          frame_done_o
);

  localparam int NS        = 2 * PASSES;
  localparam int HR        = 2 * RADIUS;
  localparam int VRING_MAX = HR * MAX_WIDTH;
  localparam int SW        = $clog2(NS);
  localparam int PW        = $clog2(NS + 1);
  localparam int MW        = $clog2(HR + 1);
  localparam int NW        = $clog2(HR + 2);
  localparam int SUMW      = 8 + NW;
  localparam int DCW       = $clog2(SUMW);
  localparam int HRW       = $clog2(HR);
  localparam int VW        = $clog2(VRING_MAX + 1);
  localparam int LW        = $clog2(RADIUS * MAX_WIDTH + 1);
  localparam int RW_DEPTH  = PASSES * HR;
  localparam int LM_DEPTH  = PASSES * VRING_MAX;
  localparam int RWA       = $clog2(RW_DEPTH);
  localparam int LMA       = $clog2(LM_DEPTH);
  localparam int PRW       = 8 + ibbt_pkg::TINT_W;
  localparam int QW        = PRW + 13;
  localparam int FW        = ibbt_pkg::FW_W;
  localparam int FH        = ibbt_pkg::FH_W;
  localparam int TC        = ibbt_pkg::TC_W;

  ibbt_pkg::bk_state_e state_q, state_d;

  logic [SW-1:0]   s_q, s_d;
  logic [MW-1:0]   m_q, m_d;
  logic [VW-1:0]   addr_q, addr_d;
  logic [TC-1:0]   tc_q, tc_d;
  logic            tapv_q, tapv_d;
  logic [SUMW-1:0] sum_q [3];
  logic [SUMW-1:0] sum_d [3];
  logic [SUMW-1:0] dv_q  [3];
  logic [SUMW-1:0] dv_d  [3];
  logic [NW-1:0]   rem_q [3];
  logic [NW-1:0]   rem_d [3];
  logic [NW-1:0]   n_q, n_d;
  logic [DCW-1:0]  dcnt_q, dcnt_d;
  logic [ibbt_pkg::PIX_W-1:0] vin_q, vin_d;
  logic [PRW-1:0]  prod_q [3];
  logic [PRW-1:0]  prod_d [3];

  logic [FW-1:0]   w_q, w_d;
  logic [FH-1:0]   h_q, h_d;
  logic [VW-1:0]   ringv_q, ringv_d;
  logic [FW-1:0]   px_q [NS+1];
  logic [FW-1:0]   px_d [NS+1];
  logic [FH-1:0]   py_q [NS+1];
  logic [FH-1:0]   py_d [NS+1];
  logic [NS:0]     pd_q, pd_d;
  logic [LW-1:0]   lead_q [NS];
  logic [LW-1:0]   lead_d [NS];
  logic [VW-1:0]   wp_q [NS];
  logic [VW-1:0]   wp_d [NS];

  logic                       out_valid_q, out_valid_d, done_out_q, done_out_d;
  logic [ibbt_pkg::PIX_W-1:0] pix_out_q, pix_out_d;

  logic [ibbt_pkg::PIX_W-1:0] rw_mem [RW_DEPTH];
  logic [ibbt_pkg::PIX_W-1:0] lm_mem [LM_DEPTH];
  logic [ibbt_pkg::PIX_W-1:0] rw_rd_q, lm_rd_q, tap_pix;
  logic [RWA-1:0]  rw_a;
  logic [LMA-1:0]  lm_a;
  logic            rw_we, lm_we, mem_we;
  logic [VW-1:0]   mem_local;

  logic [NS:0]     act;
  logic            is_v, oact, out_free, tap_ok;
  logic [SW-1:0]   pass_idx;
  logic [PW-1:0]   s_nx;
  logic [VW-1:0]   step, ring, addr_next;
  logic [TC-1:0]   lim;
  logic [ibbt_pkg::TINT_W-1:0] tsat, mul;

  // Stage k sees in-frame indices once every stage before it has filled.
  always_comb begin
    act[0] = 1'b1;
    for (int k = 1; k <= NS; k++) begin
      act[k] = act[k-1] && (lead_q[k-1] == '0);
    end
  end

  assign is_v      = s_q[0];
  assign pass_idx  = s_q >> 1;
  assign s_nx      = PW'(s_q) + PW'(1);
  assign oact      = act[PW'(s_q)] && (lead_q[s_q] == '0) && !pd_q[s_nx];
  assign out_free  = !out_valid_q || out_ready_i;
  assign step      = is_v ? VW'(w_q) : VW'(1);
  assign ring      = is_v ? ringv_q : VW'(HR);
  assign addr_next = (addr_q < step) ? addr_q + ring - step : addr_q - step;
  assign lim       = is_v ? TC'(h_q) - TC'(1) : TC'(w_q) - TC'(1);
  assign tap_ok    = !tc_q[TC-1] && ($signed(tc_q) <= $signed(lim));
  assign tap_pix   = (m_q == '0) ? vin_q : (is_v ? lm_rd_q : rw_rd_q);
  assign tsat      = (32'(tint_i) > ibbt_pkg::TINT_FULL) ?
                     ibbt_pkg::TINT_W'(ibbt_pkg::TINT_FULL) : tint_i;
  assign mul       = ibbt_pkg::TINT_W'(ibbt_pkg::TINT_FULL) - tsat;

  // Memories: one address per cycle, read in TAP, written in WRITE.
  assign mem_we    = (state_q == ibbt_pkg::BK_WRITE) && act[PW'(s_q)] && !pd_q[PW'(s_q)];
  assign rw_we     = mem_we && !is_v;
  assign lm_we     = mem_we && is_v;
  assign mem_local = (state_q == ibbt_pkg::BK_WRITE) ? wp_q[s_q] : addr_q;
  assign rw_a      = RWA'(32'(pass_idx) * HR + 32'(mem_local[HRW-1:0]));
  assign lm_a      = LMA'(32'(pass_idx) * VRING_MAX + 32'(mem_local));

  always_ff @(posedge clk_i) begin
    if (rw_we) rw_mem[rw_a] <= vin_q;
    rw_rd_q <= rw_mem[rw_a];
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) lm_mem[lm_a] <= vin_q;
    lm_rd_q <= lm_mem[lm_a];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ibbt_pkg::BK_IDLE:   if (ent_valid_i) state_d = ibbt_pkg::BK_STAGE;
      ibbt_pkg::BK_STAGE:  state_d = oact ? ibbt_pkg::BK_TAP : ibbt_pkg::BK_WRITE;
      ibbt_pkg::BK_TAP:    state_d = ibbt_pkg::BK_ACC;
      ibbt_pkg::BK_ACC:    state_d = (m_q == MW'(HR)) ? ibbt_pkg::BK_DIV : ibbt_pkg::BK_TAP;
      ibbt_pkg::BK_DIV:    if (dcnt_q == DCW'(SUMW - 1)) state_d = ibbt_pkg::BK_WRITE;
      ibbt_pkg::BK_WRITE:  state_d = (s_q == SW'(NS - 1)) ? ibbt_pkg::BK_TINT : ibbt_pkg::BK_STAGE;
      ibbt_pkg::BK_TINT:   state_d = (act[NS] && !pd_q[NS]) ? ibbt_pkg::BK_EMIT
                                                             : ibbt_pkg::BK_FINISH;
      ibbt_pkg::BK_EMIT:   if (out_free) state_d = ibbt_pkg::BK_FINISH;
      ibbt_pkg::BK_FINISH: state_d = ibbt_pkg::BK_IDLE;
      default:             state_d = ibbt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    logic [NW:0]     rs;
    logic [QW-1:0]   qx;
    logic [VW-1:0]   ring_k;
    s_d = s_q; m_d = m_q; addr_d = addr_q; tc_d = tc_q; tapv_d = tapv_q;
    n_d = n_q; dcnt_d = dcnt_q; vin_d = vin_q;
    w_d = w_q; h_d = h_q; ringv_d = ringv_q; pd_d = pd_q;
    sum_d = sum_q; dv_d = dv_q; rem_d = rem_q; prod_d = prod_q;
    px_d = px_q; py_d = py_q; lead_d = lead_q; wp_d = wp_q;
    pix_out_d = pix_out_q; done_out_d = done_out_q;
    ent_pop_o = 1'b0;
    rs = '0; qx = '0; ring_k = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ibbt_pkg::BK_IDLE: begin
        if (ent_valid_i) begin
          ent_pop_o = 1'b1;
          vin_d     = ent_i.pixel;
          s_d       = '0;
          if (ent_i.first) begin
            w_d     = ent_i.w;
            h_d     = ent_i.h;
            ringv_d = VW'(32'(HR) * 32'(ent_i.w));
            pd_d    = '0;
            for (int k = 0; k <= NS; k++) begin
              px_d[k] = '0;
              py_d[k] = '0;
            end
            for (int k = 0; k < NS; k++) begin
              wp_d[k]   = '0;
              lead_d[k] = (k % 2 == 1) ? LW'(32'(RADIUS) * 32'(ent_i.w)) : LW'(RADIUS);
            end
          end
        end
      end
      ibbt_pkg::BK_STAGE: begin
        if (oact) begin
          m_d    = '0;
          addr_d = wp_q[s_q];
          tc_d   = TC'(is_v ? 32'(py_q[s_nx]) : 32'(px_q[s_nx])) + TC'(RADIUS);
          n_d    = '0;
          for (int c = 0; c < 3; c++) sum_d[c] = '0;
        end else begin
          for (int c = 0; c < 3; c++) dv_d[c] = '0;
        end
      end
      ibbt_pkg::BK_TAP: begin
        tapv_d = tap_ok;
      end
      ibbt_pkg::BK_ACC: begin
        if (tapv_q) begin
          n_d = n_q + NW'(1);
          for (int c = 0; c < 3; c++) sum_d[c] = sum_q[c] + SUMW'(tap_pix[8*c +: 8]);
        end
        if (m_q == MW'(HR)) begin
          dcnt_d = '0;
          for (int c = 0; c < 3; c++) begin
            dv_d[c]  = sum_d[c];
            rem_d[c] = '0;
          end
        end else begin
          m_d    = m_q + MW'(1);
          addr_d = addr_next;
          tc_d   = tc_q - TC'(1);
        end
      end
      ibbt_pkg::BK_DIV: begin
        // Restoring division by the tap count, one quotient bit a cycle.
        for (int c = 0; c < 3; c++) begin
          rs = {rem_q[c], dv_q[c][SUMW-1]};
          if (rs >= {1'b0, n_q}) begin
            rem_d[c] = NW'(rs - {1'b0, n_q});
            dv_d[c]  = {dv_q[c][SUMW-2:0], 1'b1};
          end else begin
            rem_d[c] = NW'(rs);
            dv_d[c]  = {dv_q[c][SUMW-2:0], 1'b0};
          end
        end
        dcnt_d = dcnt_q + DCW'(1);
      end
      ibbt_pkg::BK_WRITE: begin
        vin_d = {dv_q[2][7:0], dv_q[1][7:0], dv_q[0][7:0]};
        if (s_q != SW'(NS - 1)) s_d = s_q + SW'(1);
      end
      ibbt_pkg::BK_TINT: begin
        for (int c = 0; c < 3; c++) prod_d[c] = PRW'(vin_q[8*c +: 8]) * PRW'(mul);
      end
      ibbt_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          // Division by 100 through a reciprocal, exact over the product range.
          for (int c = 0; c < 3; c++) begin
            qx = QW'(prod_q[c]) * QW'(ibbt_pkg::DIV100_MUL);
            pix_out_d[8*c +: 8] = qx[ibbt_pkg::DIV100_SHIFT +: 8];
          end
          done_out_d = (px_q[NS] == w_q - FW'(1)) && (py_q[NS] == h_q - FH'(1));
        end
      end
      ibbt_pkg::BK_FINISH: begin
        for (int k = 0; k <= NS; k++) begin
          if (act[k] && !pd_q[k]) begin
            if (px_q[k] == w_q - FW'(1)) begin
              px_d[k] = '0;
              if (py_q[k] == h_q - FH'(1)) pd_d[k] = 1'b1;
              else                         py_d[k] = py_q[k] + FH'(1);
            end else begin
              px_d[k] = px_q[k] + FW'(1);
            end
          end
        end
        for (int k = 0; k < NS; k++) begin
          ring_k = (k % 2 == 1) ? ringv_q : VW'(HR);
          if (act[k]) begin
            wp_d[k] = (wp_q[k] == ring_k - VW'(1)) ? '0 : wp_q[k] + VW'(1);
            if (lead_q[k] != '0) lead_d[k] = lead_q[k] - LW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ibbt_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      pd_q        <= '0;
      for (int k = 0; k < NS; k++) lead_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pd_q        <= pd_d;
      lead_q      <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d; m_q <= m_d; addr_q <= addr_d; tc_q <= tc_d; tapv_q <= tapv_d;
    n_q <= n_d; dcnt_q <= dcnt_d; vin_q <= vin_d;
    w_q <= w_d; h_q <= h_d; ringv_q <= ringv_d;
    sum_q <= sum_d; dv_q <= dv_d; rem_q <= rem_d; prod_q <= prod_d;
    px_q <= px_d; py_q <= py_d; wp_q <= wp_d;
    pix_out_q <= pix_out_d; done_out_q <= done_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pix_out_q;
  assign frame_done_o = done_out_q;

endmodule
`default_nettype wire

### hw/rtl/iterated_box_blur_with_tint.sv
// Top level of the iterated box blur with tint: config registers, front, queue, back.
// Depends on ibbt_pkg, ibbt_if, ibbt_front, ibbt_fifo and ibbt_back.
//
//  channel  dir  payload                      accepted when
//  in_ch    in   pixel_in[23:0]               valid && ready
//  out_ch   out  pixel_out[23:0], frame_done  valid && ready
//  cfg_ch   in   index[1:0], data[12:0]       valid && ready (ready held high)
//
// The back end works on one item at a time, through each of its six stages at the
// defaults, then the tint; a stage that averages reads its taps one by one and divides
// with a bit-serial divider whose width is SUMW = 8 + clog2(2*RADIUS+2). Its pace is
// set by the single line-store port, read once per tap, and the bit-serial divider.
// No clearing pass after reset. The input side stalls only when the queue is full;
// a finished result waits in the output register while the next item is worked on.
`default_nettype none
module iterated_box_blur_with_tint #(
  parameter int RADIUS    = ibbt_pkg::RADIUS_DEF,
  parameter int PASSES    = ibbt_pkg::PASSES_DEF,
  parameter int MAX_WIDTH = ibbt_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ibbt_in_if.sink       in_ch,
  ibbt_out_if.source    out_ch,
  ibbt_cfg_if.sink      cfg_ch
);

  logic [ibbt_pkg::FW_W-1:0]   fw_q;
  logic [ibbt_pkg::FH_W-1:0]   fh_q;
  logic [ibbt_pkg::TINT_W-1:0] tint_q;
  logic                        push, full, pop, f_valid;
  ibbt_pkg::fifo_entry_t       f_in, f_out;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= ibbt_pkg::FW_RESET;
      fh_q   <= ibbt_pkg::FH_RESET;
      tint_q <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == ibbt_pkg::CFG_FRAME_WIDTH)  fw_q   <= cfg_ch.data[ibbt_pkg::FW_W-1:0];
      if (cfg_ch.index == ibbt_pkg::CFG_FRAME_HEIGHT) fh_q   <= cfg_ch.data[ibbt_pkg::FH_W-1:0];
      if (cfg_ch.index == ibbt_pkg::CFG_TINT_PERCENT) tint_q <= cfg_ch.data[ibbt_pkg::TINT_W-1:0];
    end
  end

  ibbt_front #(.RADIUS(RADIUS), .PASSES(PASSES), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_ready_o     (in_ch.ready),
    .pixel_i        (in_ch.pixel_in),
    .frame_width_i  (fw_q),
    .frame_height_i (fh_q),
    .fifo_full_i    (full),
    .push_o         (push),
    .entry_o        (f_in)
  );

  ibbt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (f_valid),
    .entry_o (f_out)
  );

  ibbt_back #(.RADIUS(RADIUS), .PASSES(PASSES), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_valid_i  (f_valid),
    .ent_i        (f_out),
    .ent_pop_o    (pop),
    .tint_i       (tint_q),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .pixel_out_o  (out_ch.pixel_out),
    .frame_done_o (out_ch.frame_done)
  );

endmodule
`default_nettype wire

### hw/rtl/ibbt_checker.sv
// Port-level checks for the iterated box blur with tint, bound to the top level.
// Depends on ibbt_pkg for widths.
`default_nettype none
module ibbt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ibbt_pkg::PIX_W-1:0]  pixel_out_i,
  input logic                        frame_done_i,
  input logic                        cfg_ready_i
);

  logic [31:0] bal_q;

  // Beats taken in minus results delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_q <= '0;
    end else begin
      bal_q <= bal_q + 32'(in_valid_i && in_ready_i) - 32'(out_valid_i && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pixel_out_i) && $stable(frame_done_i))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bal_q != 32'd0)
    else $error("result without a pending input beat");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind iterated_box_blur_with_tint ibbt_checker u_ibbt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .pixel_out_i  (out_ch.pixel_out),
  .frame_done_i (out_ch.frame_done),
  .cfg_ready_i  (cfg_ch.ready)
);
`default_nettype wire

### bench/iterated_box_blur_with_tint_tb.sv
// Self-checking bench for iterated_box_blur_with_tint: frames of random and corner pixels,
// a behavioural blur/tint predictor and a scoreboard on the result channel.
// Depends on ibbt_pkg, ibbt_if and the block's RTL.
`default_nettype none
module iterated_box_blur_with_tint_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int R      = ibbt_pkg::RADIUS_DEF;
  localparam int NPASS  = ibbt_pkg::PASSES_DEF;
  localparam int MAXW   = ibbt_pkg::MAX_WIDTH_DEF;
  localparam int HRING  = 2 * R;
  localparam int VRING  = 2 * R * MAXW;
  localparam logic [ibbt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [ibbt_pkg::PIX_W-1:0] pixel;
    logic                       done;
  } blur_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ibbt_in_if  in_ch ();
  ibbt_out_if out_ch ();
  ibbt_cfg_if cfg_ch ();

  iterated_box_blur_with_tint uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  logic [ibbt_pkg::FW_W-1:0]   width_reg  = ibbt_pkg::FW_RESET;
  logic [ibbt_pkg::FH_W-1:0]   height_reg = ibbt_pkg::FH_RESET;
  logic [ibbt_pkg::TINT_W-1:0] tint_reg   = '0;
  longint                      pix_count  = 0;
  longint                      cur_w      = 1024;
  longint                      cur_h      = 768;
  logic [ibbt_pkg::PIX_W-1:0]  row_win [NPASS][HRING];
  logic [ibbt_pkg::PIX_W-1:0]  line_mem [NPASS][VRING];

  blur_result_t pending_q[$];
  int  errors     = 0;
  int  items_sent = 0;
  bit  calm       = 1'b0;
  int  hold_left  = 0;

  initial begin
    for (int p = 0; p < NPASS; p++) begin
      for (int k = 0; k < HRING; k++) row_win[p][k] = '0;
      for (int k = 0; k < VRING; k++) line_mem[p][k] = '0;
    end
  end

  function automatic logic [ibbt_pkg::PIX_W-1:0] box_mean(int unsigned sb, int unsigned sg,
                                                          int unsigned sr, int unsigned n);
    return {8'(sr / n), 8'(sg / n), 8'(sb / n)};
  endfunction

  function automatic logic [ibbt_pkg::PIX_W-1:0] h_blur(int p, longint i,
                                                        logic [ibbt_pkg::PIX_W-1:0] v,
                                                        longint npix, longint w);
    longint o, x, rs, lo, hi;
    int unsigned sb, sg, sr, n;
    logic [ibbt_pkg::PIX_W-1:0] px, res;
    res = '0;
    o = i - R;
    if (i < 0) return '0;
    if (o >= 0 && o < npix) begin
      x = o % w;
      rs = o - x;
      lo = (x >= R) ? o - R : rs;
      hi = (o + R < rs + w - 1) ? o + R : rs + w - 1;
      sb = 0; sg = 0; sr = 0; n = 0;
      for (longint j = lo; j <= hi; j++) begin
        px = (j == i) ? v : row_win[p][j % HRING];
        sb += px[7:0]; sg += px[15:8]; sr += px[23:16];
        n++;
      end
      res = box_mean(sb, sg, sr, n);
    end
    if (i < npix) row_win[p][i % HRING] = v;
    return res;
  endfunction

  function automatic logic [ibbt_pkg::PIX_W-1:0] v_blur(int p, longint i,
                                                        logic [ibbt_pkg::PIX_W-1:0] v,
                                                        longint npix, longint w, longint h);
    longint ring, o, x, y, lo, hi, j;
    int unsigned sb, sg, sr, n;
    logic [ibbt_pkg::PIX_W-1:0] px, res;
    res = '0;
    ring = 2 * R * w;
    o = i - R * w;
    if (i < 0) return '0;
    if (o >= 0 && o < npix) begin
      x = o % w;
      y = o / w;
      lo = (y >= R) ? y - R : 0;
      hi = (y + R < h - 1) ? y + R : h - 1;
      sb = 0; sg = 0; sr = 0; n = 0;
      for (longint k = lo; k <= hi; k++) begin
        j = k * w + x;
        px = (j == i) ? v : line_mem[p][j % ring];
        sb += px[7:0]; sg += px[15:8]; sr += px[23:16];
        n++;
      end
      res = box_mean(sb, sg, sr, n);
    end
    if (i < npix) line_mem[p][i % ring] = v;
    return res;
  endfunction

  function automatic logic [ibbt_pkg::PIX_W-1:0] shade_pixel(logic [ibbt_pkg::PIX_W-1:0] v);
    int unsigned t, mul;
    t = (tint_reg > ibbt_pkg::TINT_FULL) ? ibbt_pkg::TINT_FULL : tint_reg;
    mul = ibbt_pkg::TINT_FULL - t;
    return {8'(v[23:16] * mul / 100), 8'(v[15:8] * mul / 100), 8'(v[7:0] * mul / 100)};
  endfunction

  // Advances the predictor by one accepted beat; returns 1 when a result is due.
  function automatic bit blur_step(logic [ibbt_pkg::PIX_W-1:0] px, output blur_result_t res);
    longint npix, idx;
    logic [ibbt_pkg::PIX_W-1:0] v;
    res = '0;
    if (pix_count == 0) begin
      cur_w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
      cur_h = (height_reg == 0) ? 1 :
              ((height_reg > ibbt_pkg::MAX_HEIGHT) ? ibbt_pkg::MAX_HEIGHT : height_reg);
    end
    npix = cur_w * cur_h;
    idx = pix_count;
    v = px;
    for (int p = 0; p < NPASS; p++) begin
      v = h_blur(p, idx, v, npix, cur_w);
      idx -= R;
      v = v_blur(p, idx, v, npix, cur_w, cur_h);
      idx -= R * cur_w;
    end
    if (idx >= 0 && idx < npix) begin
      res.pixel = shade_pixel(v);
      res.done = (idx == npix - 1);
      pix_count = res.done ? 0 : pix_count + 1;
      return 1'b1;
    end
    pix_count++;
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [ibbt_pkg::PIX_W-1:0] got,
                                 logic [ibbt_pkg::PIX_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: ready with random idling and an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    blur_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", out_ch.pixel_out, '0);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.pixel_out !== want.pixel)
          report_mismatch("pixel_out", out_ch.pixel_out, want.pixel);
        if (out_ch.frame_done !== want.done)
          report_mismatch("frame_done", ibbt_pkg::PIX_W'(out_ch.frame_done),
                          ibbt_pkg::PIX_W'(want.done));
      end
    end
  end

  task automatic send_pixel(logic [ibbt_pkg::PIX_W-1:0] px);
    blur_result_t res;
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_in <= px;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (blur_step(px, res)) pending_q.push_back(res);
  endtask

  task automatic write_reg(logic [ibbt_pkg::CFG_IDX_W-1:0] idx,
                           logic [ibbt_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      ibbt_pkg::CFG_FRAME_WIDTH:  width_reg = data[ibbt_pkg::FW_W-1:0];
      ibbt_pkg::CFG_FRAME_HEIGHT: height_reg = data[ibbt_pkg::FH_W-1:0];
      ibbt_pkg::CFG_TINT_PERCENT: tint_reg = data[ibbt_pkg::TINT_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every pending result, then let the back end settle
  task automatic drain_idle();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  // one frame: w*h pixels then enough drain beats to flush all passes
  task automatic run_frame(logic [ibbt_pkg::CFG_DATA_W-1:0] w,
                           logic [ibbt_pkg::CFG_DATA_W-1:0] h,
                           logic [ibbt_pkg::CFG_DATA_W-1:0] tint, int style);
    int ew, eh;
    logic [ibbt_pkg::PIX_W-1:0] px;
    write_reg(ibbt_pkg::CFG_FRAME_WIDTH, w);
    write_reg(ibbt_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(ibbt_pkg::CFG_TINT_PERCENT, tint);
    ew = (w[ibbt_pkg::FW_W-1:0] == 0) ? 1 :
         ((w[ibbt_pkg::FW_W-1:0] > MAXW) ? MAXW : w[ibbt_pkg::FW_W-1:0]);
    eh = (h == 0) ? 1 : ((h > ibbt_pkg::MAX_HEIGHT) ? ibbt_pkg::MAX_HEIGHT : h);
    for (int k = 0; k < ew * eh; k++) begin
      case ($urandom_range(0, 7))
        0: px = '0;
        1: px = '1;
        2: px = 24'hFF << (8 * $urandom_range(0, 2));
        default: px = ibbt_pkg::PIX_W'($urandom());
      endcase
      if (style == 1) px = '1;
      send_pixel(px);
    end
    for (int k = 0; k < NPASS * R * (ew + 1); k++) send_pixel(ibbt_pkg::PIX_W'($urandom()));
    drain_idle();
  endtask

  task automatic test_corners();
    // a few fixed pixels through a 3x2 frame
    write_reg(ibbt_pkg::CFG_FRAME_WIDTH, 3);
    write_reg(ibbt_pkg::CFG_FRAME_HEIGHT, 2);
    write_reg(ibbt_pkg::CFG_TINT_PERCENT, 0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h0000FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF0000);
    send_pixel(24'h123456);
    for (int k = 0; k < NPASS * R * 4; k++) send_pixel(ibbt_pkg::PIX_W'($urandom()));
    drain_idle();
    // zero size counts as one
    run_frame(0, 0, 0, 0);
    // oversized writes, then replaced before any beat latches them
    write_reg(ibbt_pkg::CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(ibbt_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
    write_reg(CFG_SPARE, 13'h1FFF);
    run_frame(1, 12, 0, 0);
  endtask

  task automatic test_tint();
    run_frame(2, 3, 100, 1);
    run_frame(2, 3, 13'h1FFF, 1);
    run_frame(3, 3, 1, 1);
    run_frame(3, 2, 99, 0);
    run_frame(4, 2, 50, 0);
  endtask

  task automatic test_backpressure();
    calm = 1'b0;
    write_reg(ibbt_pkg::CFG_FRAME_WIDTH, 2);
    write_reg(ibbt_pkg::CFG_FRAME_HEIGHT, 8);
    write_reg(ibbt_pkg::CFG_TINT_PERCENT, 25);
    hold_left = 6000;
    for (int k = 0; k < 16; k++) send_pixel(ibbt_pkg::PIX_W'($urandom()));
    for (int k = 0; k < NPASS * R * 3; k++) send_pixel(ibbt_pkg::PIX_W'($urandom()));
    drain_idle();
  endtask

  task automatic test_random();
    int fr;
    logic [ibbt_pkg::CFG_DATA_W-1:0] fw, fh, ft;
    fr = 0;
    while (items_sent < 950) begin
      // first random frame runs with no idling on either side
      calm = (fr == 0);
      fw = ibbt_pkg::CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(7, 12)
                                                              : $urandom_range(0, 6));
      fh = ibbt_pkg::CFG_DATA_W'($urandom_range(1, 16));
      ft = ibbt_pkg::CFG_DATA_W'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 127));
      run_frame(fw, fh, ft, 0);
      fr++;
    end
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pixel_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ibbt_pkg::CFG_FRAME_WIDTH;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_tint();
    test_backpressure();
    test_random();
    drain_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
